// File: hdl/peq_pkg.sv
// Package for the priority event queue: shared constants and codes.
// No dependencies; used by priority_event_queue_unit.
package peq_pkg;

  localparam int unsigned LEVELS        = 3;
  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned LEVEL_W       = 2;

  // Item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic [CODE_W-1:0] EMPTY_CODE_RST = '0;

endpackage

// File: hdl/peq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module peq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/priority_event_queue_unit.sv
// Top level of the priority event queue: three event rings, strict priority fetch.
// Depends on peq_pkg and peq_ram.
//
//  channel   signals                                   direction  transaction when
//  ------    ----------------------------------------  ---------  --------------------
//  command   start, kind, level, event_code, busy      in         start && !busy
//  result    done, fetched_code, found, found_level,   out        every cycle done is high
//            dropped_oldest
//  config    cfg_valid, cfg_data, cfg_ready            in         cfg_valid && cfg_ready
//
// Each command passes from acceptance to its result strobe through the input
// register and then the pointer logic, whose registered RAM read lands with
// the result register. A new command is taken every cycle while busy is low;
// throughput is one per clock. busy is high during reset and in the first
// cycle after it; the RAM needs no clearing pass, as only written entries are
// ever read. The receiver cannot stall, so done is never held back.
// Configuration is taken at any time, ready is always high.
module priority_event_queue_unit #(
  parameter int unsigned DEPTH = peq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // command
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [peq_pkg::LEVEL_W-1:0] level,
  input  logic [peq_pkg::CODE_W-1:0]  event_code,
  // result
  output logic                        done,
  output logic [peq_pkg::CODE_W-1:0]  fetched_code,
  output logic                        found,
  output logic [peq_pkg::LEVEL_W-1:0] found_level,
  output logic                        dropped_oldest,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [peq_pkg::CODE_W-1:0]  cfg_data
);

  localparam int unsigned LEVELS = peq_pkg::LEVELS;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RAM_D  = LEVELS * DEPTH;
  localparam int unsigned ADDR_W = $clog2(RAM_D);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  // Ring increment without modulo
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Flat RAM address: level base plus slot
  function automatic logic [ADDR_W-1:0] ram_addr(input logic [peq_pkg::LEVEL_W-1:0] l,
                                                 input logic [PTR_W-1:0] p);
    return ADDR_W'(l) * ADDR_W'(DEPTH) + ADDR_W'(p);
  endfunction

  // Configuration register
  logic [peq_pkg::CODE_W-1:0] empty_code;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code <= peq_pkg::EMPTY_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      empty_code <= cfg_data;
    end
  end

  // busy only covers reset and the cycle straight after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Input register
  logic                        s1_valid;
  logic                        s1_kind;
  logic [peq_pkg::LEVEL_W-1:0] s1_level;
  logic [peq_pkg::CODE_W-1:0]  s1_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_kind  <= kind;
    s1_level <= level;
    s1_code  <= event_code;
  end

  // Ring pointers
  logic [PTR_W-1:0] rd_ptr      [LEVELS];
  logic [PTR_W-1:0] wr_ptr      [LEVELS];
  logic [PTR_W-1:0] rd_ptr_next [LEVELS];
  logic [PTR_W-1:0] wr_ptr_next [LEVELS];

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [peq_pkg::CODE_W-1:0]  ram_rdata;

  logic                        hit;
  logic [peq_pkg::LEVEL_W-1:0] hit_level;
  logic                        drop;

  always_comb begin
    logic [PTR_W-1:0] wp_adv;
    logic [PTR_W-1:0] hit_rp;
    hit       = 1'b0;
    hit_level = '0;
    hit_rp    = '0;
    wp_adv    = '0;
    drop      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    for (int l = 0; l < LEVELS; l++) begin
      rd_ptr_next[l] = rd_ptr[l];
      wr_ptr_next[l] = wr_ptr[l];
    end
    // Priority pick: lowest non-empty level wins, so scan from the bottom up
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (rd_ptr[l] != wr_ptr[l]) begin
        hit       = 1'b1;
        hit_level = peq_pkg::LEVEL_W'(l);
        hit_rp    = rd_ptr[l];
      end
    end
    if (s1_valid) begin
      if (s1_kind == peq_pkg::KIND_STORE) begin
        hit = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
          if (s1_level == peq_pkg::LEVEL_W'(l)) begin
            wp_adv         = ring_next(wr_ptr[l]);
            ram_we         = 1'b1;
            ram_waddr      = ram_addr(s1_level, wr_ptr[l]);
            wr_ptr_next[l] = wp_adv;
            // Full ring: push the read pointer past the oldest entry, which is lost
            if (rd_ptr[l] == wp_adv) begin
              rd_ptr_next[l] = ring_next(wp_adv);
              drop           = 1'b1;
            end
          end
        end
      end else if (hit) begin
        ram_re    = 1'b1;
        ram_raddr = ram_addr(hit_level, hit_rp);
        for (int l = 0; l < LEVELS; l++) begin
          if (hit_level == peq_pkg::LEVEL_W'(l)) begin
            rd_ptr_next[l] = ring_next(hit_rp);
          end
        end
      end
    end else begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        rd_ptr[l] <= '0;
        wr_ptr[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        rd_ptr[l] <= rd_ptr_next[l];
        wr_ptr[l] <= wr_ptr_next[l];
      end
    end
  end

  peq_ram #(
    .WIDTH (peq_pkg::CODE_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (s1_code),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Result register
  logic                        s2_valid;
  logic                        s2_fetch;
  logic                        s2_found;
  logic [peq_pkg::LEVEL_W-1:0] s2_level;
  logic                        s2_drop;
  logic [peq_pkg::CODE_W-1:0]  s2_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_fetch <= (s1_kind == peq_pkg::KIND_FETCH);
    s2_found <= hit;
    s2_level <= hit ? hit_level : '0;
    s2_drop  <= drop;
    s2_empty <= empty_code;
  end

  // Popped code comes straight from the RAM's read register
  assign done           = s2_valid;
  assign fetched_code   = s2_found ? ram_rdata : (s2_fetch ? s2_empty : '0);
  assign found          = s2_found;
  assign found_level    = s2_level;
  assign dropped_oldest = s2_drop;

endmodule

// File: verif/tb_priority_event_queue_unit.sv
// Testbench for priority_event_queue_unit: directed table, then three random phases.
// Checks every result strobe against an in-bench model of the three event rings, or the row's typed outcome.
// Depends on peq_pkg and the RTL under hdl/.
module tb_priority_event_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = peq_pkg::DEPTH_DEFAULT;
  localparam int          CYCLE_LIMIT = 200_000;

  // Priority levels as carried on the level field; the fourth value is not a level.
  localparam logic [peq_pkg::LEVEL_W-1:0] LVL_HIGH = 2'd0;
  localparam logic [peq_pkg::LEVEL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [peq_pkg::LEVEL_W-1:0] LVL_LOW  = 2'd2;
  localparam logic [peq_pkg::LEVEL_W-1:0] LVL_BAD  = 2'd3;

  // One result transaction, field for field as on the result ports.
  typedef struct packed {
    logic [peq_pkg::CODE_W-1:0]  code;
    logic                        found;
    logic [peq_pkg::LEVEL_W-1:0] src_level;
    logic                        dropped;
  } outcome_t;

  localparam outcome_t EMPTY_AT_RESET = '{code: peq_pkg::EMPTY_CODE_RST, found: 1'b0,
                                          src_level: '0, dropped: 1'b0};
  localparam outcome_t NO_EFFECT      = '0;

  // Directed stimulus. typed = 1: the expected outcome is written in the row,
  // otherwise it comes from the ring model.
  typedef struct packed {
    logic                        kind;
    logic [peq_pkg::LEVEL_W-1:0] level;
    logic [peq_pkg::CODE_W-1:0]  code;
    logic                        typed;
    outcome_t                    exp;
  } directed_row_t;

  localparam int N_DIRECTED = 24;
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b1, EMPTY_AT_RESET}, // empty after reset
    '{peq_pkg::KIND_STORE, LVL_BAD,  8'hFF, 1'b1, NO_EFFECT},      // level three: ignored
    '{peq_pkg::KIND_FETCH, LVL_BAD,  8'hFF, 1'b1, EMPTY_AT_RESET}, // still empty
    '{peq_pkg::KIND_STORE, LVL_LOW,  8'h00, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_MID,  8'hFF, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'hA5, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_FETCH, LVL_LOW,  8'h00, 1'b0, NO_EFFECT},      // high first
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT},      // then medium
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT},      // then low
    '{peq_pkg::KIND_FETCH, LVL_MID,  8'h5A, 1'b1, EMPTY_AT_RESET}, // drained again
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h01, 1'b0, NO_EFFECT},      // fill the high ring
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h02, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h03, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h04, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h05, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h06, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h07, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h08, 1'b0, NO_EFFECT},      // full: oldest lost
    '{peq_pkg::KIND_STORE, LVL_HIGH, 8'h5A, 1'b0, NO_EFFECT},      // and again
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT},
    '{peq_pkg::KIND_FETCH, LVL_HIGH, 8'h00, 1'b0, NO_EFFECT}
  };

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                        clk;
  logic                        rst        = 1'b1;
  logic                        start      = 1'b0;
  logic                        busy;
  logic                        cmd_kind   = peq_pkg::KIND_STORE;
  logic [peq_pkg::LEVEL_W-1:0] cmd_level  = '0;
  logic [peq_pkg::CODE_W-1:0]  cmd_code   = '0;
  logic                        done;
  logic [peq_pkg::CODE_W-1:0]  fetched_code;
  logic                        found;
  logic [peq_pkg::LEVEL_W-1:0] found_level;
  logic                        dropped_oldest;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  logic [peq_pkg::CODE_W-1:0]  cfg_data   = '0;

  // Sideband travelling with each command: a typed-in expectation, if any.
  logic     row_typed   = 1'b0;
  outcome_t row_outcome = '0;

  priority_event_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (cmd_kind),
    .level          (cmd_level),
    .event_code     (cmd_code),
    .done           (done),
    .fetched_code   (fetched_code),
    .found          (found),
    .found_level    (found_level),
    .dropped_oldest (dropped_oldest),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring model: own copy of the three rings, their pointers and the idle code.
  // ---------------------------------------------------------------------------
  logic [peq_pkg::CODE_W-1:0] ring_model [peq_pkg::LEVELS][DEPTH];
  int                         rd_ptr     [peq_pkg::LEVELS];
  int                         wr_ptr     [peq_pkg::LEVELS];
  logic [peq_pkg::CODE_W-1:0] idle_code_model;

  outcome_t pending_outcomes [$];  // expected results, oldest first
  int       mismatches = 0;

  // Applies one command to the model and returns the result it must produce.
  function automatic outcome_t predict_event_outcome(input logic k,
                                                     input logic [peq_pkg::LEVEL_W-1:0] lv,
                                                     input logic [peq_pkg::CODE_W-1:0] c);
    outcome_t o;
    int       w;
    o = '0;
    if (k == peq_pkg::KIND_STORE) begin
      if (lv < peq_pkg::LEVELS) begin
        w = wr_ptr[lv];
        ring_model[lv][w] = c;
        w = (w + 1) % DEPTH;
        wr_ptr[lv] = w;
        // write pointer caught up with read pointer: lose the oldest entry
        if (rd_ptr[lv] == w) begin
          rd_ptr[lv] = (w + 1) % DEPTH;
          o.dropped = 1'b1;
        end
      end
    end else begin
      o.code = idle_code_model;
      for (int l = 0; l < peq_pkg::LEVELS; l++) begin
        if (!o.found && rd_ptr[l] != wr_ptr[l]) begin
          o.code      = ring_model[l][rd_ptr[l]];
          o.found     = 1'b1;
          o.src_level = l[peq_pkg::LEVEL_W-1:0];
          rd_ptr[l]   = (rd_ptr[l] + 1) % DEPTH;
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the NBAs of that
  // edge land, so driver and DUT are seen with the same pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    outcome_t got;
    outcome_t want;
    outcome_t predicted;
    if (rst) begin
      for (int l = 0; l < peq_pkg::LEVELS; l++) begin
        rd_ptr[l] = 0;
        wr_ptr[l] = 0;
        for (int s = 0; s < DEPTH; s++) ring_model[l][s] = '0;
      end
      idle_code_model = peq_pkg::EMPTY_CODE_RST;
      pending_outcomes.delete();
    end else begin
      // result strobe: one transaction per cycle with done high
      if (done) begin
        got = {fetched_code, found, found_level, dropped_oldest};
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result code=%h found=%b level=%0d dropped=%b",
                     $realtime, got.code, got.found, got.src_level, got.dropped);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.code !== want.code || got.found !== want.found ||
              got.src_level !== want.src_level || got.dropped !== want.dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch code exp %h got %h, found exp %b got %b, ",
                        "level exp %0d got %0d, dropped exp %b got %b"},
                       $realtime, want.code, got.code, want.found, got.found,
                       want.src_level, got.src_level, want.dropped, got.dropped);
          end
        end
      end
      // config transaction: only issued while idle, so order against commands is moot
      if (cfg_valid && cfg_ready) idle_code_model = cfg_data;
      // command transaction
      if (start && !busy) begin
        predicted = predict_event_outcome(cmd_kind, cmd_level, cmd_code);
        pending_outcomes.push_back(row_typed ? row_outcome : predicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All DUT inputs change by NBA just after a rising edge.
  // ---------------------------------------------------------------------------

  // Presents one command and holds it until the handshake completes.
  task automatic issue_event(input logic k, input logic [peq_pkg::LEVEL_W-1:0] lv,
                             input logic [peq_pkg::CODE_W-1:0] c, input logic typed,
                             input outcome_t exp);
    start       <= 1'b1;
    cmd_kind    <= k;
    cmd_level   <= lv;
    cmd_code    <= c;
    row_typed   <= typed;
    row_outcome <= exp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random sender gap of random length, taken with the given percentage.
  task automatic maybe_pause(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_idle_code(input logic [peq_pkg::CODE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic in windows of 16 commands: each window is either store-heavy
  // (rings fill and wrap) or fetch-heavy (rings drain and the idle code shows),
  // and most stores go to one focus level so that it overflows.
  task automatic run_random_phase(input int n_items, input int idle_pct);
    int                          store_pct;
    logic [peq_pkg::LEVEL_W-1:0] focus;
    logic                        k;
    logic [peq_pkg::LEVEL_W-1:0] lv;
    store_pct = 50;
    focus     = LVL_HIGH;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) begin
        store_pct = $urandom_range(1) ? 80 : 25;
        focus     = peq_pkg::LEVEL_W'($urandom_range(2));
      end
      // hold off once per phase until the pipe is empty
      if (i == n_items / 2) wait_drained();
      maybe_pause(idle_pct);
      k = ($urandom_range(99) < store_pct) ? peq_pkg::KIND_STORE : peq_pkg::KIND_FETCH;
      if ($urandom_range(99) < 5)       lv = LVL_BAD;
      else if ($urandom_range(99) < 60) lv = focus;
      else                              lv = peq_pkg::LEVEL_W'($urandom_range(2));
      issue_event(k, lv, peq_pkg::CODE_W'($urandom_range(255)), 1'b0, NO_EFFECT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_idle_code(8'h00);
    for (int r = 0; r < N_DIRECTED; r++) begin
      maybe_pause(21);
      issue_event(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].level, DIRECTED_ROWS[r].code,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
    end
    wait_drained();

    // sender gaps at 21 %, idle code at its top value
    write_idle_code(8'hFF);
    run_random_phase(125, 21);
    wait_drained();

    // sender gaps at 73 %, some other idle code
    write_idle_code(peq_pkg::CODE_W'($urandom_range(254, 1)));
    run_random_phase(125, 73);
    wait_drained();

    // back-to-back commands, idle code at zero
    write_idle_code(8'h00);
    run_random_phase(125, 0);
    wait_drained();

    // spare cycles after the drain catch any stray strobe
    repeat (6) @(posedge clk);
    if (pending_outcomes.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: ends a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/peq_pkg.sv
hdl/peq_ram.sv
hdl/priority_event_queue_unit.sv
verif/tb_priority_event_queue_unit.sv
